>>> rtl/wsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; every other rtl file refers to this package by scoped name.
package wsd_pkg;

    localparam int unsigned CFG_ADDR_W    = 2;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd4194304;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] opcode;
        logic [7:0] data;
        logic       last;
        logic       masked;
    } result_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

>>> rtl/wsd_parser.sv
`timescale 1ns / 1ps
// Front end: header parser that classifies each accepted byte and builds result entries.
// Depends on wsd_pkg.
module wsd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          stream_byte,
    input  logic                stream_start,
    input  logic [31:0]         max_payload,
    output logic                push,
    output wsd_pkg::result_t    push_entry
);

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic [3:0]  ext_left_reg, ext_left_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [2:0]  key_left_reg, key_left_next;
    logic [1:0]  mpos_reg, mpos_next;
    logic [31:0] pleft_reg, pleft_next;
    logic        halt_reg, halt_next;

    logic        len_done;
    logic        pay_start;
    logic [6:0]  len7;
    logic [7:0]  key_byte;
    logic [31:0] pleft_dec;

    always_comb
    begin
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        mask_next     = mask_reg;
        ext_left_next = ext_left_reg;
        len_next      = len_reg;
        key_next      = key_reg;
        key_left_next = key_left_reg;
        mpos_next     = mpos_reg;
        pleft_next    = pleft_reg;
        halt_next     = halt_reg;
        len_done      = 1'b0;
        pay_start     = 1'b0;
        len7          = stream_byte[6:0];
        key_byte      = 8'd0;
        pleft_dec     = 32'd0;
        push          = 1'b0;
        push_entry    = '0;

        if (accept)
        begin
            if (stream_start)
            begin
                phase_next    = PH_HDR0;
                opcode_next   = 4'd0;
                mask_next     = 1'b0;
                ext_left_next = 4'd0;
                len_next      = 64'd0;
                key_next      = 32'd0;
                key_left_next = 3'd0;
                mpos_next     = 2'd0;
                pleft_next    = 32'd0;
                halt_next     = 1'b0;
            end

            if (!halt_next)
            begin
                pleft_dec = pleft_next - 32'd1;
                case (mpos_next)
                    2'd0:    key_byte = key_next[31:24];
                    2'd1:    key_byte = key_next[23:16];
                    2'd2:    key_byte = key_next[15:8];
                    default: key_byte = key_next[7:0];
                endcase
                if (!mask_next)
                begin
                    key_byte = 8'd0;
                end

                case (phase_next)
                    PH_HDR1:
                    begin
                        mask_next = stream_byte[7];
                        if (len7 == wsd_pkg::LEN_EXT16)
                        begin
                            len_next      = 64'd0;
                            ext_left_next = 4'd2;
                            phase_next    = PH_EXT;
                        end
                        else if (len7 == wsd_pkg::LEN_EXT64)
                        begin
                            len_next      = 64'd0;
                            ext_left_next = 4'd8;
                            phase_next    = PH_EXT;
                        end
                        else
                        begin
                            len_next = {57'd0, len7};
                            len_done = 1'b1;
                        end
                    end
                    PH_EXT:
                    begin
                        len_next      = {len_next[55:0], stream_byte};
                        ext_left_next = ext_left_next - 4'd1;
                        len_done      = (ext_left_next == 4'd0);
                    end
                    PH_KEY:
                    begin
                        key_next      = {key_next[23:0], stream_byte};
                        key_left_next = key_left_next - 3'd1;
                        pay_start     = (key_left_next == 3'd0);
                    end
                    PH_DATA:
                    begin
                        mpos_next         = mpos_next + 2'd1;
                        pleft_next        = pleft_dec;
                        push              = 1'b1;
                        push_entry.kind   = wsd_pkg::KIND_DATA;
                        push_entry.data   = stream_byte ^ key_byte;
                        push_entry.last   = (pleft_dec == 32'd0);
                        if (pleft_dec == 32'd0)
                        begin
                            phase_next = PH_HDR0;
                        end
                    end
                    default:
                    begin
                        opcode_next = stream_byte[3:0];
                        phase_next  = PH_HDR1;
                    end
                endcase

                if (len_done)
                begin
                    if (len_next > {32'd0, max_payload})
                    begin
                        halt_next       = 1'b1;
                        phase_next      = PH_HDR0;
                        push            = 1'b1;
                        push_entry.kind = wsd_pkg::KIND_ERROR;
                        push_entry.last = 1'b1;
                    end
                    else if (mask_next)
                    begin
                        key_left_next = 3'd4;
                        phase_next    = PH_KEY;
                    end
                    else
                    begin
                        pay_start = 1'b1;
                    end
                end

                if (pay_start)
                begin
                    mpos_next  = 2'd0;
                    pleft_next = len_next[31:0];
                    if (len_next[31:0] == 32'd0)
                    begin
                        phase_next      = PH_HDR0;
                        push            = 1'b1;
                        push_entry.kind = wsd_pkg::KIND_EMPTY;
                        push_entry.last = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end

                push_entry.opcode = opcode_next;
                push_entry.masked = mask_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            opcode_reg   <= 4'd0;
            mask_reg     <= 1'b0;
            ext_left_reg <= 4'd0;
            len_reg      <= 64'd0;
            key_reg      <= 32'd0;
            key_left_reg <= 3'd0;
            mpos_reg     <= 2'd0;
            pleft_reg    <= 32'd0;
            halt_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            mask_reg     <= mask_next;
            ext_left_reg <= ext_left_next;
            len_reg      <= len_next;
            key_reg      <= key_next;
            key_left_reg <= key_left_next;
            mpos_reg     <= mpos_next;
            pleft_reg    <= pleft_next;
            halt_reg     <= halt_next;
        end
    end

endmodule

>>> rtl/wsd_queue.sv
`timescale 1ns / 1ps
// Small result queue between the parser and the output stage.
// Depends on wsd_pkg.
module wsd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  wsd_pkg::result_t      push_entry,
    input  logic                  pop,
    output wsd_pkg::result_t      head,
    output wsd_pkg::q_status_t    status
);

    wsd_pkg::result_t                 slot_reg [wsd_pkg::Q_DEPTH];
    logic [wsd_pkg::Q_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [wsd_pkg::Q_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [wsd_pkg::Q_CNT_W-1:0]      count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        head         = slot_reg[rd_ptr_reg];
        status.empty = (count_reg == '0);
        status.full  = (count_reg == wsd_pkg::Q_CNT_W'(wsd_pkg::Q_DEPTH));
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/wsd_out.sv
`timescale 1ns / 1ps
// Back end: output register that drains the result queue onto the result channel.
// Depends on wsd_pkg.
module wsd_out (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wsd_pkg::result_t      head,
    input  wsd_pkg::q_status_t    q_status,
    input  logic                  out_stall,
    output logic                  pop,
    output logic                  out_valid,
    output wsd_pkg::result_t      out_entry
);

    logic             valid_reg, valid_next;
    wsd_pkg::result_t entry_reg;

    always_comb
    begin
        pop        = !q_status.empty && (!valid_reg || !out_stall);
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        out_valid = valid_reg;
        out_entry = entry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            entry_reg <= head;
        end
    end

endmodule

>>> rtl/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// Top level of the WebSocket frame deframer: config register, parser, queue, output stage.
// Depends on wsd_pkg, wsd_parser, wsd_queue and wsd_out.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one stream byte per transaction;
//   stream_start marks the first byte of a new connection and restarts parsing.
//   Result channel (out_valid / out_stall) carries at most one result per input
//   byte: unmasked payload bytes, an empty-frame marker, or a length error after
//   which bytes are dropped until the next stream start.
//   The APB port holds max_payload_bytes at address 0; write it only while idle.
//   Throughput: one byte per cycle while in_stall is low; the parser updates all its
//   state as each byte is taken. The parser writes a result into the four-entry queue
//   at the edge that takes its byte, and the output register loads it from the queue
//   once that register is empty or out_stall is low, and then raises out_valid.
//   When the receiver stalls, the queue fills; in_stall rises once it holds four
//   results, while bytes that give no result are taken as long as room remains.
//   Reset empties the queue and output, clears parse state and restores the
//   limit to 4194304.
module websocket_frame_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [wsd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [wsd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    stream_byte,
    input  logic                          stream_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    result_kind,
    output logic [3:0]                    frame_opcode_out,
    output logic [7:0]                    payload_byte,
    output logic                          last_in_frame,
    output logic                          was_masked
);

    logic [31:0]         max_payload_reg, max_payload_next;
    logic                in_accept;
    logic                q_push;
    logic                q_pop;
    wsd_pkg::result_t    push_entry;
    wsd_pkg::result_t    q_head;
    wsd_pkg::result_t    out_entry;
    wsd_pkg::q_status_t  q_stat;

    always_comb
    begin
        pready           = 1'b1;
        max_payload_next = max_payload_reg;
        if (psel && penable && pwrite && paddr == wsd_pkg::REG_MAX_PAYLOAD)
        begin
            max_payload_next = pwdata;
        end
        prdata = (paddr == wsd_pkg::REG_MAX_PAYLOAD) ? max_payload_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= wsd_pkg::MAX_PAYLOAD_RESET;
        end
        else
        begin
            max_payload_reg <= max_payload_next;
        end
    end

    assign in_stall  = q_stat.full;
    assign in_accept = in_valid && !in_stall;

    wsd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .stream_byte  (stream_byte),
        .stream_start (stream_start),
        .max_payload  (max_payload_reg),
        .push         (q_push),
        .push_entry   (push_entry)
    );

    wsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_stat)
    );

    wsd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_status  (q_stat),
        .out_stall (out_stall),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_entry (out_entry)
    );

    assign result_kind      = out_entry.kind;
    assign frame_opcode_out = out_entry.opcode;
    assign payload_byte     = out_entry.data;
    assign last_in_frame    = out_entry.last;
    assign was_masked       = out_entry.masked;

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("result pushed into a full queue");

    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind != wsd_pkg::KIND_DATA) |->
            (last_in_frame && payload_byte == 8'd0))
        else $error("marker or error result is not a clean last result");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!q_stat.empty))
        else $error("output became valid with an empty queue");

endmodule
